[rtl/rss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record selection sorter package
// Shared sizes, command and status types for the sorter controller and
// datapath.
// ----------------------------------------------------------------------------
package rss_pkg;

    // Capacity of one batch (legal range 2 to 64).
    localparam int MAX_RECORDS = 32;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 32;
    localparam int PAY_W       = 32;
    localparam int WORD_W      = KEY_W + PAY_W;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [WORD_W-1:0] t_word;

    // Source of the record store write data.
    typedef enum logic [1:0] {
        WSEL_IN   = 2'd0,
        WSEL_POS  = 2'd1,
        WSEL_BEST = 2'd2
    } t_wsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_wsel wsel;
        t_idx  raddr;
        logic  cap_first;
        logic  cmp_en;
        logic  load_out;
        logic  out_last;
        logic  out_ovf;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic less;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/rss_rec_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record input channel
// Valid/ready channel that carries one unsorted record per transfer.
// ----------------------------------------------------------------------------
interface rss_rec_if;
    import rss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] record_key;
    logic signed [PAY_W-1:0] record_payload;
    logic                    last_record;

    modport source (output valid, output record_key, output record_payload,
                    output last_record, input ready);
    modport sink   (input valid, input record_key, input record_payload,
                    input last_record, output ready);
endinterface

[rtl/rss_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted record output channel
// Valid/ready channel that carries one sorted record per transfer.
// ----------------------------------------------------------------------------
interface rss_out_if;
    import rss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] sorted_key;
    logic signed [PAY_W-1:0] sorted_payload;
    logic                    end_of_batch;
    logic                    overflow;

    modport source (output valid, output sorted_key, output sorted_payload,
                    output end_of_batch, output overflow, input ready);
    modport sink   (input valid, input sorted_key, input sorted_payload,
                    input end_of_batch, input overflow, output ready);
endinterface

[rtl/rss_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/rss_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter datapath
// Record store, running minimum, swap holding registers and output register.
// ----------------------------------------------------------------------------
module rss_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rss_pkg::t_dp_cmd                 i_cmd,
    output rss_pkg::t_dp_sts                 o_sts,
    input  logic signed [rss_pkg::KEY_W-1:0] i_rec_key,
    input  logic signed [rss_pkg::PAY_W-1:0] i_rec_payload,
    rss_out_if.source                        o_sorted
);
    import rss_pkg::*;

    t_word r_best;
    t_word r_pos;
    t_word wdata;
    t_word rdata;
    logic  r_out_valid;
    t_word r_out_word;
    logic  r_out_last;
    logic  r_out_ovf;

    // Write data select: incoming record or one side of a swap.
    always_comb begin
        case (i_cmd.wsel)
            WSEL_IN:   wdata = {i_rec_key, i_rec_payload};
            WSEL_POS:  wdata = r_pos;
            WSEL_BEST: wdata = r_best;
            default:   wdata = {i_rec_key, i_rec_payload};
        endcase
    end

    rss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (wdata),
        .i_raddr (i_cmd.raddr),
        .o_rdata (rdata)
    );

    // Strict signed compare of the record just read against the minimum.
    assign o_sts.less = $signed(rdata[WORD_W-1:PAY_W]) < $signed(r_best[WORD_W-1:PAY_W]);
    assign o_sts.out_free = !r_out_valid || o_sorted.ready;

    // Running minimum and the record at the pass boundary.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_first) begin
            r_best <= rdata;
            r_pos  <= rdata;
        end else if (i_cmd.cmp_en && o_sts.less) begin
            r_best <= rdata;
        end
    end

    // Output register, emptied by a transfer on the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_sorted.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_word <= rdata;
            r_out_last <= i_cmd.out_last;
            r_out_ovf  <= i_cmd.out_ovf;
        end
    end

    assign o_sorted.valid          = r_out_valid;
    assign o_sorted.sorted_key     = r_out_word[WORD_W-1:PAY_W];
    assign o_sorted.sorted_payload = r_out_word[PAY_W-1:0];
    assign o_sorted.end_of_batch   = r_out_last;
    assign o_sorted.overflow       = r_out_ovf;
endmodule

[rtl/rss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter controller
// Sequences loading, selection sort passes and output of one batch.
// ----------------------------------------------------------------------------
module rss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    input  logic             i_last_record,
    output logic             o_rec_ready,
    output rss_pkg::t_dp_cmd o_cmd,
    input  rss_pkg::t_dp_sts i_sts
);
    import rss_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_FIRST,
        S_SCAN,
        S_SWAP_BEST,
        S_SWAP_POS,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_ovf, n_ovf;
    t_idx   r_last_idx, n_last_idx;
    t_idx   r_pos, n_pos;
    t_idx   r_rd_idx, n_rd_idx;
    t_idx   r_best_idx, n_best_idx;
    logic   accept;
    logic   room;

    assign o_rec_ready = (r_state == S_LOAD);
    assign accept      = i_rec_valid && o_rec_ready;
    assign room        = (r_count < t_cnt'(MAX_RECORDS));

    // Next state, counters and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_last_idx = r_last_idx;
        n_pos      = r_pos;
        n_rd_idx   = r_rd_idx;
        n_best_idx = r_best_idx;
        o_cmd      = '0;
        o_cmd.wsel = WSEL_IN;
        case (r_state)
            S_LOAD: begin
                o_cmd.waddr = r_count[IDX_W-1:0];
                if (accept) begin
                    if (room) begin
                        o_cmd.we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_record) begin
                        n_last_idx = room ? r_count[IDX_W-1:0] : t_idx'(MAX_RECORDS - 1);
                        n_count    = '0;
                        n_pos      = '0;
                        n_state    = (n_last_idx == '0) ? S_OUT_RD : S_PASS;
                    end
                end
            end
            S_PASS: begin
                o_cmd.raddr = r_pos;
                n_state     = S_FIRST;
            end
            S_FIRST: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.raddr     = r_pos + 1'b1;
                n_best_idx      = r_pos;
                n_rd_idx        = r_pos + 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.cmp_en = 1'b1;
                o_cmd.raddr  = r_rd_idx + 1'b1;
                if (i_sts.less) begin
                    n_best_idx = r_rd_idx;
                end
                if (r_rd_idx == r_last_idx) begin
                    n_state = S_SWAP_BEST;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_SWAP_BEST: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = r_best_idx;
                o_cmd.wsel  = WSEL_POS;
                n_state     = S_SWAP_POS;
            end
            S_SWAP_POS: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = r_pos;
                o_cmd.wsel  = WSEL_BEST;
                if (r_pos + 1'b1 == r_last_idx) begin
                    n_pos   = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_PASS;
                end
            end
            S_OUT_RD: begin
                o_cmd.raddr = r_pos;
                if (i_sts.out_free) begin
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_last = (r_pos == r_last_idx);
                o_cmd.out_ovf  = r_ovf;
                if (r_pos == r_last_idx) begin
                    n_pos   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_pos      <= '0;
            r_last_idx <= '0;
            r_rd_idx   <= '0;
            r_best_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_pos      <= n_pos;
            r_last_idx <= n_last_idx;
            r_rd_idx   <= n_rd_idx;
            r_best_idx <= n_best_idx;
        end
    end
endmodule

[rtl/record_selection_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record selection sorter
// Collects a batch of key/payload records and emits them sorted by key.
// ----------------------------------------------------------------------------
// Records arrive on i_rec, one per transfer; last_record closes the batch.
// Up to MAX_RECORDS records are stored; later ones are dropped and every
// result of that batch carries overflow. While loading, one record is taken
// per cycle. After the closing transfer the block sorts with selection sort
// over a single record store RAM (one write and one read port). Each pass
// reads position p, scans the positions after it up to n-1 for the minimum
// key and swaps that record with position p. Results then leave through an
// output register on o_sorted, each read from the store before it is loaded;
// end_of_batch marks the final one. The next batch starts loading as soon as
// the final result is in the output register. If the receiver stalls, the
// emit sequence waits with that register full. i_rec.ready is low from the
// closing transfer until the final result is loaded. Reset empties the
// batch and the output register; store contents are not cleared.
// ----------------------------------------------------------------------------
module record_selection_sorter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rss_rec_if.sink   i_rec,
    rss_out_if.source o_sorted
);
    import rss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (i_rec.valid),
        .i_last_record (i_rec.last_record),
        .o_rec_ready   (i_rec.ready),
        .o_cmd         (cmd),
        .i_sts         (sts)
    );

    rss_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_rec_key     (i_rec.record_key),
        .i_rec_payload (i_rec.record_payload),
        .o_sorted      (o_sorted)
    );

`ifndef NO_ASSERTIONS
    // Results within one batch come out in non-decreasing key order.
    a_sorted_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sorted.valid && o_sorted.ready && !o_sorted.end_of_batch |=>
        !o_sorted.valid ||
        ($signed(o_sorted.sorted_key) >= $signed($past(o_sorted.sorted_key))))
        else $error("sorted keys out of order within a batch");

    // The overflow flag is the same on every result of one batch.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sorted.valid && o_sorted.ready && !o_sorted.end_of_batch |=>
        !o_sorted.valid || (o_sorted.overflow == $past(o_sorted.overflow)))
        else $error("overflow flag changed within a batch");

    // No record is taken right after a batch is closed.
    a_closed_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec.valid && i_rec.ready && i_rec.last_record |=> !i_rec.ready)
        else $error("input accepted while a batch is being sorted");
`endif
endmodule
